[hw/rtl/eati_pkg.sv]
// Package with shared types and constants for the encoder angle interpolator.
package eati_pkg;

    localparam int DEPTH = 1024;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [24:0] FULL_CIRCLE = 25'd23592960;
    localparam logic [24:0] HALF_CIRCLE = 25'd11796480;
    localparam logic [26:0] WIN_RESET = 27'd1000000;

    localparam logic [2:0] CASE_EMPTY  = 3'd0;
    localparam logic [2:0] CASE_SINGLE = 3'd1;
    localparam logic [2:0] CASE_BEFORE = 3'd2;
    localparam logic [2:0] CASE_INTERP = 3'd3;
    localparam logic [2:0] CASE_EXTRAP = 3'd4;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [47:0] time_us;
        logic [15:0] encoder_count;
    } eati_in_t;

    typedef struct packed {
        logic [24:0] angle_q16;
        logic [2:0]  case_code;
        logic        stale;
    } eati_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;    // capture the transaction and start the count conversion
        logic push_write;  // append the converted sample
        logic prune_rd;    // read the oldest sample
        logic prune_drop;  // drop the oldest sample if too old
        logic srch_init;
        logic srch_rd;     // read sample at mid
        logic srch_step;   // update bounds from read data
        logic pair_rd1;    // read earlier bracketing sample
        logic pair_rd2;    // read later bracketing sample
        logic mul_step;    // one multiplier partial product
        logic div_init;
        logic div_step;    // one restoring division step
        logic finish;      // form the result
    } eati_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic prune_more;   // oldest sample is older than the window
        logic srch_done;
        logic trivial;      // result needs no division
        logic mul_done;
        logic div_done;
    } eati_sts_t;

endpackage

[hw/rtl/eati_datapath.sv]
// Datapath: sample memory, search bounds, multiplier and serial divider.
module eati_datapath
    import eati_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [26:0] cfg_wr_data,
    input  eati_in_t    in_item,
    input  eati_cmd_t   cmd,
    output eati_sts_t   sts,
    output eati_out_t   result
);

    // Sample memory, one word of time and angle.
    logic [72:0] mem [DEPTH];
    logic [72:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    logic [26:0] win_reg;
    logic [AW-1:0] oldest_reg;
    logic [CW-1:0] count_reg;
    logic [24:0] last_angle_reg;
    eati_in_t    item_reg;
    logic [24:0] conv_angle_reg;

    logic [CW-1:0] lo_reg, hi_reg;
    logic [CW-1:0] mid;
    logic [47:0] t1_reg, t2_reg;
    logic [24:0] v1_reg;
    logic [24:0] v2_reg;

    logic [47:0] qd, den;
    logic [25:0] mag;
    logic        neg;
    logic signed [26:0] base;
    logic [73:0] prod_reg;
    logic [1:0]  mcnt_reg;
    logic [73:0] dq_reg;
    logic [48:0] rem_reg;
    logic [6:0]  dcnt_reg;
    logic [24:0] qmod_reg;
    logic [2:0]  code_reg;
    logic        stale_reg;
    logic        trivial_reg;
    logic [24:0] triv_angle_reg;

    // Count to angle conversion: (c*23592960 + 32767) / 65535, by reciprocal.
    logic [40:0] conv_num;
    logic [40:0] conv_q0;
    logic [57:0] conv_pr;
    logic [40:0] conv_r;
    always_comb begin
        conv_num = 41'(item_reg.encoder_count) * 41'(FULL_CIRCLE) + 41'd32767;
        // q0 = floor(n*(1 + 1/65536)/65536) approximation, corrected below
        conv_pr = 58'(conv_num) * 58'd65537;
        conv_q0 = 41'(conv_pr >> 32);
        conv_r = conv_num - conv_q0 * 41'd65535;
    end

    function automatic logic [24:0] red(input logic signed [27:0] x);
        logic signed [27:0] y;
        y = x;
        if (y < 0) y = y + 28'(FULL_CIRCLE);
        if (y >= 28'(FULL_CIRCLE)) y = y - 28'(FULL_CIRCLE);
        return y[24:0];
    endfunction

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Read address: the oldest sample unless a search or bracketing read asks otherwise.
    always_comb begin
        rd_en = cmd.prune_rd | cmd.srch_rd | cmd.pair_rd1 | cmd.pair_rd2;
        rd_addr = oldest_reg;
        if (cmd.srch_rd) rd_addr = oldest_reg + mid[AW-1:0];
        else if (cmd.pair_rd1) begin
            if (lo_reg == '0 || count_reg < CW'(2)) rd_addr = oldest_reg;
            else if (lo_reg == count_reg) rd_addr = oldest_reg + AW'(count_reg - 2);
            else rd_addr = oldest_reg + AW'(lo_reg - 1);
        end else if (cmd.pair_rd2) begin
            rd_addr = (lo_reg == count_reg) ? oldest_reg + AW'(count_reg - 1)
                                            : oldest_reg + lo_reg[AW-1:0];
        end
    end

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.push_write) mem[oldest_reg + count_reg[AW-1:0]] <=
                {item_reg.time_us, conv_angle_reg};
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // Interpolation operands.
    logic signed [26:0] d0, d1;
    logic signed [26:0] v2w;
    logic extra;
    always_comb begin
        extra = (code_reg == CASE_EXTRAP);
        d0 = $signed({2'b0, v2_reg}) - $signed({2'b0, v1_reg});
        v2w = $signed({2'b0, v2_reg});
        if (d0 > $signed({2'b0, HALF_CIRCLE})) v2w = v2w - $signed({2'b0, FULL_CIRCLE});
        else if (d0 < -$signed({2'b0, HALF_CIRCLE})) v2w = v2w + $signed({2'b0, FULL_CIRCLE});
        d1 = v2w - $signed({2'b0, v1_reg});
        neg = d1[26];
        mag = neg ? 26'(-d1) : 26'(d1);
        qd = extra ? item_reg.time_us - t2_reg : item_reg.time_us - t1_reg;
        den = t2_reg - t1_reg;
        // The wrap correction moves a base by a full circle, so the reduced raw
        // angle serves; triv_angle_reg holds the reduced later angle here.
        base = extra ? $signed({2'b0, triv_angle_reg}) : $signed({2'b0, red(28'(v1_reg))});
    end

    logic [49:0] rshift;
    always_comb rshift = {rem_reg, dq_reg[73]};

    // Quotient residue modulo a full circle, built as the quotient bits arrive.
    logic        qbit;
    logic [25:0] qmod_dbl;
    logic [24:0] qmod_next;
    always_comb begin
        qbit = (rshift >= 50'(den));
        qmod_dbl = {qmod_reg, qbit};
        qmod_next = (qmod_dbl >= 26'(FULL_CIRCLE)) ? 25'(qmod_dbl - 26'(FULL_CIRCLE))
                                                    : qmod_dbl[24:0];
    end

    // Rounded offset and final value.
    logic [48:0] rem2;
    logic [25:0] off_inc;
    logic [24:0] off;
    logic signed [27:0] fin;
    always_comb begin
        rem2 = {rem_reg[47:0], 1'b0};
        off_inc = {1'b0, qmod_reg} + ((rem2 >= {1'b0, den}) ? 26'd1 : 26'd0);
        off = (off_inc == 26'(FULL_CIRCLE)) ? '0 : off_inc[24:0];
        fin = neg ? 28'(base) - 28'(off) : 28'(base) + 28'(off);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
            oldest_reg <= '0;
            count_reg <= '0;
            last_angle_reg <= '0;
        end else begin
            if (cfg_wr_en) win_reg <= cfg_wr_data;
            if (cmd.push_write) begin
                last_angle_reg <= conv_angle_reg;
                if (count_reg == CW'(DEPTH)) oldest_reg <= oldest_reg + 1'b1;
                else count_reg <= count_reg + 1'b1;
            end
            if (cmd.prune_drop && sts.prune_more) begin
                oldest_reg <= oldest_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) item_reg <= in_item;
        conv_angle_reg <= (conv_r >= 41'd65535) ? 25'(conv_q0 + 41'd1) : 25'(conv_q0);
        if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= count_reg;
            trivial_reg <= 1'b1;
            stale_reg <= 1'b0;
            if (count_reg == '0) begin
                code_reg <= CASE_EMPTY;
                triv_angle_reg <= red(28'(last_angle_reg));
            end else if (count_reg == CW'(1)) begin
                code_reg <= CASE_SINGLE;
            end else begin
                code_reg <= CASE_INTERP;
            end
        end
        if (cmd.srch_step) begin
            if (rd_data_reg[72:25] < item_reg.time_us) lo_reg <= mid + 1'b1;
            else hi_reg <= mid;
        end
        if (cmd.pair_rd1 && code_reg == CASE_INTERP && lo_reg == count_reg)
            code_reg <= CASE_EXTRAP;
        if (cmd.pair_rd2) begin
            // The oldest sample or the earlier bracketing sample arrives here.
            if (code_reg == CASE_SINGLE) begin
                triv_angle_reg <= red(28'(rd_data_reg[24:0]));
            end else if (code_reg == CASE_INTERP || code_reg == CASE_EXTRAP) begin
                if (lo_reg == '0) begin
                    code_reg <= CASE_BEFORE;
                    triv_angle_reg <= red(28'(rd_data_reg[24:0]));
                    stale_reg <= (rd_data_reg[72:25] - item_reg.time_us) > 48'(win_reg);
                end else begin
                    t1_reg <= rd_data_reg[72:25];
                    v1_reg <= rd_data_reg[24:0];
                end
            end
        end
        if (cmd.mul_step && mcnt_reg == 2'd0) begin
            t2_reg <= rd_data_reg[72:25];
            v2_reg <= rd_data_reg[24:0];
            if (code_reg == CASE_INTERP || code_reg == CASE_EXTRAP) begin
                trivial_reg <= (rd_data_reg[72:25] <= t1_reg);
                triv_angle_reg <= red(28'(rd_data_reg[24:0]));
                if (code_reg == CASE_EXTRAP)
                    stale_reg <= (item_reg.time_us - rd_data_reg[72:25]) > 48'(win_reg);
            end else begin
                trivial_reg <= 1'b1;
            end
        end
        // Product mag * qd formed as two 26x24 partial products.
        if (cmd.mul_step) begin
            if (mcnt_reg == 2'd1) prod_reg <= 74'(mag * qd[23:0]);
            else if (mcnt_reg == 2'd2) prod_reg <= prod_reg + (74'(mag * qd[47:24]) << 24);
            mcnt_reg <= mcnt_reg + 1'b1;
        end
        if (cmd.srch_init) mcnt_reg <= '0;
        if (cmd.div_init) begin
            dq_reg <= prod_reg;
            rem_reg <= '0;
            dcnt_reg <= '0;
            qmod_reg <= '0;
        end
        if (cmd.div_step) begin
            if (qbit) begin
                rem_reg <= 49'(rshift - 50'(den));
                dq_reg <= {dq_reg[72:0], 1'b1};
            end else begin
                rem_reg <= rshift[48:0];
                dq_reg <= {dq_reg[72:0], 1'b0};
            end
            qmod_reg <= qmod_next;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.finish) begin
            result.case_code <= code_reg;
            result.stale <= stale_reg;
            result.angle_q16 <= trivial_reg ? triv_angle_reg : red(fin);
        end
    end

    always_comb begin
        sts.is_query = (item_reg.req_type == REQ_QUERY);
        sts.prune_more = (count_reg != '0) &&
                         (49'(rd_data_reg[72:25]) + 49'(win_reg) < 49'(item_reg.time_us));
        sts.srch_done = (lo_reg >= hi_reg);
        sts.trivial = trivial_reg;
        sts.mul_done = (mcnt_reg == 2'd3);
        sts.div_done = (dcnt_reg == 7'd74);
    end

endmodule

[hw/rtl/eati_ctrl.sv]
// Controller state machine sequencing pushes, pruning and queries.
module eati_ctrl
    import eati_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  eati_sts_t sts,
    output eati_cmd_t cmd
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_DEC   = 13'b0000000000010,
        ST_CONV  = 13'b0000000000100,
        ST_PRD   = 13'b0000000001000,
        ST_PCHK  = 13'b0000000010000,
        ST_SINIT = 13'b0000000100000,
        ST_SRD   = 13'b0000001000000,
        ST_SCHK  = 13'b0000010000000,
        ST_PAIR1 = 13'b0000100000000,
        ST_PAIR2 = 13'b0001000000000,
        ST_MUL   = 13'b0010000000000,
        ST_DIV   = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.latch_in = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: state_next = sts.is_query ? ST_SINIT : ST_CONV;
            ST_CONV: begin
                cmd.push_write = 1'b1;
                state_next = ST_PRD;
            end
            ST_PRD: begin
                cmd.prune_rd = 1'b1;
                state_next = ST_PCHK;
            end
            ST_PCHK: begin
                cmd.prune_drop = 1'b1;
                state_next = sts.prune_more ? ST_PRD : ST_IDLE;
            end
            ST_SINIT: begin
                cmd.srch_init = 1'b1;
                state_next = ST_SRD;
            end
            ST_SRD: begin
                if (sts.srch_done) begin
                    state_next = ST_PAIR1;
                end else begin
                    cmd.srch_rd = 1'b1;
                    state_next = ST_SCHK;
                end
            end
            ST_SCHK: begin
                cmd.srch_step = 1'b1;
                state_next = ST_SRD;
            end
            ST_PAIR1: begin
                cmd.pair_rd1 = 1'b1;
                state_next = ST_PAIR2;
            end
            ST_PAIR2: begin
                cmd.pair_rd2 = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_done) begin
                    cmd.div_init = 1'b1;
                    state_next = sts.trivial ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_FIN;
                else cmd.div_step = 1'b1;
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.finish) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

endmodule

[hw/rtl/encoder_angle_time_interpolator_unit.sv]
// Top level of the encoder angle time interpolator.
//  channel | ports            | carries
//  input   | s_valid/s_ready  | eati_in_t push or query transaction
//  output  | m_valid/m_ready  | eati_out_t query result transaction
//  config  | cfg_wr_en        | max_window_us, 27 bits
// A push writes its sample, then drops the oldest samples one by one while they are older
// than the window.
// A query runs a binary search, at most 11 steps for a full ring, reads the bracketing
// pair and, when interpolating or extrapolating, divides at one quotient bit per cycle.
// Reset is synchronous on aresetn low; the sample memory is not cleared.
// A waiting result holds the next query in its last cycle until m_ready; pushes go on.
module encoder_angle_time_interpolator_unit
    import eati_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  eati_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output eati_out_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [26:0] cfg_wr_data
);

    eati_cmd_t cmd;
    eati_sts_t sts;

    eati_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    eati_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data), .in_item(s_data), .cmd(cmd), .sts(sts),
        .result(m_data)
    );

endmodule

[hw/rtl/eati_checker.sv]
// Port-level checker for the encoder angle time interpolator, with its bind.
module eati_checker
    import eati_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input eati_out_t m_data
);

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.case_code <= CASE_EXTRAP)
        else $error("bad case code");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.angle_q16 < FULL_CIRCLE)
        else $error("angle out of range");

    a_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stale |->
            (m_data.case_code == CASE_BEFORE || m_data.case_code == CASE_EXTRAP))
        else $error("stale flag on wrong case");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted two transactions back to back");

endmodule

bind encoder_angle_time_interpolator_unit eati_checker u_eati_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
